@@ hw/rtl/sndw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sndw_pkg;

   // Widths of the transfer fields.
   localparam int VALUE_W = 32;
   localparam int ADDR_W  = 4;
   localparam int CODE_W  = 4;

   // Decimal digits needed for the magnitude of any 32-bit signed number.
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = BCD_DIGITS * CODE_W;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);

   // Display codes and register numbers.
   localparam logic [CODE_W-1:0] CODE_BLANK      = 4'hF;
   localparam logic [CODE_W-1:0] CODE_MINUS      = 4'hA;
   localparam logic [CODE_W-1:0] CODE_ZERO       = 4'h0;
   localparam logic [ADDR_W-1:0] FIRST_DIGIT_REG = 4'h1;

   // Digit count register.
   localparam int                MAX_DIGITS_DEFAULT = 8;
   localparam logic [ADDR_W-1:0] DIGIT_COUNT_RESET  = 4'd8;

   // Sequencer to converter.
   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] mag;
   } conv_req_type;

   // Converter to sequencer: done stays high until the next start.
   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } conv_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/sndw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Number channel.
interface sndw_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sndw_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// Register write channel towards the display driver.
interface sndw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sndw_pkg::ADDR_W-1:0]  reg_addr;
   logic [sndw_pkg::CODE_W-1:0]  reg_data;
   logic                         last;

   modport source (output valid, output reg_addr, output reg_data, output last, input ready);
   modport sink (input valid, input reg_addr, input reg_data, input last, output ready);
endinterface

// Digit count register write channel.
interface sndw_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sndw_pkg::ADDR_W-1:0]  digit_count;

   modport source (output valid, output digit_count, input ready);
   modport sink (input valid, input digit_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sndw_bcd_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module sndw_bcd_conv (
   input  wire                     clock,
   input  wire                     reset,
   input  sndw_pkg::conv_req_type  conv_req,
   output sndw_pkg::conv_rsp_type  conv_rsp
);

   logic [sndw_pkg::VALUE_W-1:0]   bin_ff, bin_in;
   logic [sndw_pkg::BCD_W-1:0]     bcd_ff, bcd_in;
   logic [sndw_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sndw_pkg::BCD_W-1:0]     adjusted;

   // Add three to every digit of five or more before the next shift.
   always_comb begin
      for (int i = 0; i < sndw_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i*sndw_pkg::CODE_W +: sndw_pkg::CODE_W] >= 4'd5) begin
            adjusted[i*sndw_pkg::CODE_W +: sndw_pkg::CODE_W] =
               bcd_ff[i*sndw_pkg::CODE_W +: sndw_pkg::CODE_W] + 4'd3;
         end else begin
            adjusted[i*sndw_pkg::CODE_W +: sndw_pkg::CODE_W] =
               bcd_ff[i*sndw_pkg::CODE_W +: sndw_pkg::CODE_W];
         end
      end
   end

   // Next state: load on start, otherwise shift one binary bit into the digits.
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (conv_req.start) begin
         bin_in  = conv_req.mag;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         bin_in = {bin_ff[sndw_pkg::VALUE_W-2:0], 1'b0};
         bcd_in = {adjusted[sndw_pkg::BCD_W-2:0], bin_ff[sndw_pkg::VALUE_W-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sndw_pkg::BIT_CNT_W'(sndw_pkg::VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign conv_rsp.done = done_ff;
   assign conv_rsp.bcd  = bcd_ff;

`ifndef SYNTHESIS
   // A result is never reported while bits are still being shifted in.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("converter reports done while busy");

   // Every conversion takes the full word width of shifts.
   a_done_after_last_bit: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(cnt_ff) == sndw_pkg::BIT_CNT_W'(sndw_pkg::VALUE_W - 1))
      else $error("converter finished early");

   // The top and bottom digits of the result are decimal digits.
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> (bcd_ff[sndw_pkg::BCD_W-1 -: sndw_pkg::CODE_W] <= 4'd9)
                         && (bcd_ff[sndw_pkg::CODE_W-1:0] <= 4'd9))
      else $error("converter produced a digit above nine");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sndw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Write sequencer: blanks the display, then sends digits and sign one nibble a cycle while the output is not stalled.
module sndw_seq #(
   parameter int MAX_DIGITS = sndw_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [sndw_pkg::ADDR_W-1:0]     digit_count,
   sndw_req_if.sink                       req_port,
   sndw_rsp_if.source                     rsp_port,
   output sndw_pkg::conv_req_type         conv_req,
   input  sndw_pkg::conv_rsp_type         conv_rsp
);

   localparam logic [sndw_pkg::ADDR_W-1:0] MaxCount = sndw_pkg::ADDR_W'(MAX_DIGITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLANK,
      ST_WAIT,
      ST_DIGIT,
      ST_SIGN
   } state_type;

   state_type                     state_ff, state_in;
   logic [sndw_pkg::ADDR_W-1:0]   reg_ff, reg_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   logic [sndw_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sndw_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [sndw_pkg::CODE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [sndw_pkg::ADDR_W-1:0]   eff_count;
   logic [sndw_pkg::VALUE_W-1:0]  raw;
   logic                          accept;
   logic                          advance;
   logic                          rest_zero;
   logic                          sign_fits;
   logic                          final_digit;

   // Digit count in use: zero counts as one, large values saturate.
   always_comb begin
      if (digit_count == '0) begin
         eff_count = sndw_pkg::FIRST_DIGIT_REG;
      end else if (digit_count > MaxCount) begin
         eff_count = MaxCount;
      end else begin
         eff_count = digit_count;
      end
   end

   assign raw     = req_port.value;
   assign accept  = req_port.valid && (state_ff == ST_IDLE);
   assign advance = !rsp_valid_ff || rsp_port.ready;

   // Magnitude of the number goes to the converter with the start pulse.
   assign conv_req.start = accept;
   assign conv_req.mag   = raw[sndw_pkg::VALUE_W-1] ? (sndw_pkg::VALUE_W'(0) - raw) : raw;

   // Decisions for the digit now at the bottom of the shift register.
   assign rest_zero   = (bcd_ff[sndw_pkg::BCD_W-1:sndw_pkg::CODE_W] == '0);
   assign sign_fits   = neg_ff && (reg_ff < eff_count);
   assign final_digit = (reg_ff == eff_count) || (rest_zero && !sign_fits);

   // Next state and next output transfer.
   always_comb begin
      state_in     = state_ff;
      reg_in       = reg_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      bcd_in       = bcd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               reg_in   = eff_count;
               neg_in   = raw[sndw_pkg::VALUE_W-1];
               zero_in  = (raw == '0);
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = reg_ff;
               rsp_data_in  = sndw_pkg::CODE_BLANK;
               rsp_last_in  = 1'b0;
               if (reg_ff == sndw_pkg::FIRST_DIGIT_REG) begin
                  state_in = ST_WAIT;
               end else begin
                  reg_in = reg_ff - 1'b1;
               end
            end
         end
         ST_WAIT: begin
            if (conv_rsp.done) begin
               bcd_in   = conv_rsp.bcd;
               reg_in   = sndw_pkg::FIRST_DIGIT_REG;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = reg_ff;
               if (zero_ff) begin
                  rsp_data_in = sndw_pkg::CODE_ZERO;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_data_in = bcd_ff[sndw_pkg::CODE_W-1:0];
                  rsp_last_in = final_digit;
                  reg_in      = reg_ff + 1'b1;
                  bcd_in      = {sndw_pkg::CODE_W'(0), bcd_ff[sndw_pkg::BCD_W-1:sndw_pkg::CODE_W]};
                  if (final_digit) begin
                     state_in = ST_IDLE;
                  end else if (rest_zero) begin
                     state_in = ST_SIGN;
                  end
               end
            end
         end
         ST_SIGN: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = reg_ff;
               rsp_data_in  = sndw_pkg::CODE_MINUS;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reg_ff      <= reg_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      bcd_ff      <= bcd_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_port.ready    = (state_ff == ST_IDLE);
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.reg_addr = rsp_addr_ff;
   assign rsp_port.reg_data = rsp_data_ff;
   assign rsp_port.last     = rsp_last_ff;

`ifndef SYNTHESIS
   // Every write lands in a digit register that is in use.
   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_addr_ff >= sndw_pkg::FIRST_DIGIT_REG) && (rsp_addr_ff <= eff_count))
      else $error("register write outside the digit count");

   // A blanking write never closes a run.
   a_blank_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff == sndw_pkg::CODE_BLANK) |-> !rsp_last_ff)
      else $error("blank write marked as last");

   // The sign is only sent for a negative number.
   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> neg_ff)
      else $error("minus sign for a non-negative number");

   // The converter only returns all-zero digits for a zero input.
   a_nonzero_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) && conv_rsp.done |-> (conv_rsp.bcd != '0) || zero_ff)
      else $error("zero digits for a nonzero number");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/signed_number_digit_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Order: the first blanking write is registered once the number is taken and blanking starts;
// the first digit write follows a load, 32 one-bit shifts and a hand-over to the digit state.
// Blanking runs while the converter shifts, so it adds nothing unless the output stalls.
// Flow: one number at a time; the next is taken once the last digit or sign write of the
// number before it is queued.
// Reset: synchronous, active high; the digit count returns to 8, nothing is pending.
module signed_number_digit_writer #(
   parameter int MAX_DIGITS = sndw_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   sndw_req_if.sink     req_port,
   sndw_rsp_if.source   rsp_port,
   sndw_csr_if.sink     csr_port
);

   logic [sndw_pkg::ADDR_W-1:0] digit_count_ff, digit_count_in;
   sndw_pkg::conv_req_type      conv_req;
   sndw_pkg::conv_rsp_type      conv_rsp;

   // Digit count register, written by any transfer on the register channel.
   assign csr_port.ready = 1'b1;

   always_comb begin
      digit_count_in = digit_count_ff;
      if (csr_port.valid) begin
         digit_count_in = csr_port.digit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= sndw_pkg::DIGIT_COUNT_RESET;
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   sndw_bcd_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .conv_rsp (conv_rsp)
   );

   sndw_seq #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .digit_count (digit_count_ff),
      .req_port    (req_port),
      .rsp_port    (rsp_port),
      .conv_req    (conv_req),
      .conv_rsp    (conv_rsp)
   );

endmodule

`default_nettype wire
